@@ rtl/scsa_pkg.sv @@
// Shared types, constants and codes for the size-class slab allocator.
// Used by scsa_seq and the top level under rtl/; depends on nothing.
`timescale 1ns / 1ps

package scsa_pkg;

  localparam int DEF_MAX_CLASSES = 64;
  localparam int DEF_MAX_CHUNKS  = 256;

  localparam int GS_W       = 4;
  localparam int UNITS_W    = 7;
  localparam int USED_W     = 7;
  localparam int REQ_W      = 16;
  localparam int ADDR_W     = 22;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // granule is at least 8 bytes, at most 256 bytes
  localparam logic [GS_W-1:0] MIN_GRAIN_SHIFT = 4'd3;
  localparam logic [GS_W-1:0] MAX_GRAIN_SHIFT = 4'd8;

  localparam logic [GS_W-1:0]    RST_GRAIN_SHIFT = 4'd3;
  localparam logic [UNITS_W-1:0] RST_CHUNK_UNITS = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAIN_SHIFT = 8'd0,
    REG_CHUNK_UNITS = 8'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_RESET = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_LOOK,
    S_PICK,
    S_BASE,
    S_OFF,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    cmd_t             command;
    logic [REQ_W-1:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] address;
  } out_item_t;

  // effective (clamped) configuration handed to the sequencer
  typedef struct packed {
    logic [GS_W-1:0]    grain_shift;
    logic [UNITS_W-1:0] units;
  } cfg_t;

endpackage

@@ rtl/scsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/scsa_mac.sv @@
// Shared multiply-accumulate unit with a registered result.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module scsa_mac #(
  parameter int A_W = 8,
  parameter int B_W = 7,
  parameter int P_W = A_W + B_W + 1
) (
  input  logic           clk,
  input  logic           en,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [P_W-1:0] c,
  output logic [P_W-1:0] p_r
);

  logic [A_W+B_W-1:0] prod;
  logic [P_W-1:0]     p_nxt;

  assign prod  = a * b;
  assign p_nxt = P_W'(prod) + c;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

@@ rtl/scsa_seq.sv @@
// Allocation sequencer: chunk counters, class valid bits, slot table and output register.
// Depends on scsa_pkg, scsa_ram and scsa_mac.
`timescale 1ns / 1ps

module scsa_seq #(
  parameter int MAX_CLASSES = scsa_pkg::DEF_MAX_CLASSES,
  parameter int MAX_CHUNKS  = scsa_pkg::DEF_MAX_CHUNKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scsa_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  scsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scsa_pkg::out_item_t out_data
);

  import scsa_pkg::*;

  localparam int CLS_W   = MAX_CLASSES > 1 ? $clog2(MAX_CLASSES) : 1;
  localparam int CHUNK_W = MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
  localparam int ENT_W   = CHUNK_W + USED_W;
  localparam int A_W     = CHUNK_W > USED_W + 1 ? CHUNK_W : USED_W + 1;
  localparam int B_W     = UNITS_W;
  localparam int P_W     = A_W + B_W + 1;
  localparam int SUM_W   = REQ_W + 1;

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       taken_r, taken_nxt;
  logic [CNT_W-1:0]       recyc_r, recyc_nxt;
  logic [MAX_CLASSES-1:0] valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [UNITS_W-1:0] grains_r, grains_nxt;
  logic [CLS_W-1:0]   k_r, k_nxt;
  logic               vld_r, vld_nxt;
  logic [CHUNK_W-1:0] rd_chunk_r, rd_chunk_nxt;
  logic [USED_W-1:0]  rd_used_r, rd_used_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  status_t            status_r, status_nxt;
  logic               use_addr_r, use_addr_nxt;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] grains_full;
  logic             bad_size;
  logic             need_chunk;
  logic             out_free;
  logic             in_accept;

  logic               ram_we;
  logic [ENT_W-1:0]   ram_wdata;
  logic [ENT_W-1:0]   ram_rdata;
  logic [CLS_W-1:0]   ram_raddr;

  logic               mac_en;
  logic [A_W-1:0]     mac_a;
  logic [B_W-1:0]     mac_b;
  logic [P_W-1:0]     mac_c;
  logic [P_W-1:0]     mac_p;

  logic [ADDR_W+P_W-1:0] addr_wide;

  scsa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_CLASSES)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(k_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  scsa_mac #(
    .A_W(A_W),
    .B_W(B_W),
    .P_W(P_W)
  ) u_mac (
    .clk(clk),
    .en (mac_en),
    .a  (mac_a),
    .b  (mac_b),
    .c  (mac_c),
    .p_r(mac_p)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // round the request up to whole granules
  assign sum         = {1'b0, req_r} + ((SUM_W'(1) << cfg.grain_shift) - SUM_W'(1));
  assign grains_full = sum >> cfg.grain_shift;
  assign bad_size    = (grains_full == '0) || (grains_full > SUM_W'(cfg.units));
  assign ram_raddr   = CLS_W'(grains_full - SUM_W'(1));

  // used >= units/grains  <=>  (used+1)*grains > units
  assign need_chunk = !vld_r || (mac_p > P_W'(cfg.units));

  assign ram_wdata = {chunk_r, used_r + USED_W'(1)};
  assign addr_wide = (ADDR_W+P_W)'(mac_p) << cfg.grain_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taken_r     <= '0;
      recyc_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      recyc_r     <= recyc_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    req_r      <= req_nxt;
    grains_r   <= grains_nxt;
    k_r        <= k_nxt;
    vld_r      <= vld_nxt;
    rd_chunk_r <= rd_chunk_nxt;
    rd_used_r  <= rd_used_nxt;
    chunk_r    <= chunk_nxt;
    used_r     <= used_nxt;
    status_r   <= status_nxt;
    use_addr_r <= use_addr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    taken_nxt     = taken_r;
    recyc_nxt     = recyc_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    req_nxt       = req_r;
    grains_nxt    = grains_r;
    k_nxt         = k_r;
    vld_nxt       = vld_r;
    rd_chunk_nxt  = rd_chunk_r;
    rd_used_nxt   = rd_used_r;
    chunk_nxt     = chunk_r;
    used_nxt      = used_r;
    status_nxt    = status_r;
    use_addr_nxt  = use_addr_r;
    ram_we        = 1'b0;
    mac_en        = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    mac_c         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          req_nxt      = in_data.request_bytes;
          status_nxt   = ST_OK;
          use_addr_nxt = 1'b0;
          state_nxt    = S_DONE;
          case (in_data.command)
            CMD_ALLOC: state_nxt = S_SIZE;
            CMD_RESET: begin
              recyc_nxt = taken_r;
              valid_nxt = '0;
            end
            CMD_CLEAR: begin
              taken_nxt = '0;
              recyc_nxt = '0;
              valid_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      S_SIZE: begin
        // slot table read is issued here at the class index
        grains_nxt = UNITS_W'(grains_full);
        k_nxt      = ram_raddr;
        if (bad_size) begin
          status_nxt = ST_BAD_SIZE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        rd_chunk_nxt = ram_rdata[ENT_W-1:USED_W];
        rd_used_nxt  = ram_rdata[USED_W-1:0];
        vld_nxt      = valid_r[k_r];
        mac_en       = 1'b1;
        mac_a        = A_W'({1'b0, ram_rdata[USED_W-1:0]} + (USED_W+1)'(1));
        mac_b        = grains_r;
        state_nxt    = S_PICK;
      end

      S_PICK: begin
        chunk_nxt = rd_chunk_r;
        used_nxt  = rd_used_r;
        state_nxt = S_BASE;
        if (need_chunk) begin
          used_nxt = '0;
          if (recyc_r != '0) begin
            // recycled chunks go out newest first
            recyc_nxt = recyc_r - CNT_W'(1);
            chunk_nxt = CHUNK_W'(recyc_r - CNT_W'(1));
          end else if (taken_r < CNT_W'(MAX_CHUNKS)) begin
            taken_nxt = taken_r + CNT_W'(1);
            chunk_nxt = CHUNK_W'(taken_r);
          end else begin
            status_nxt = ST_EXHAUSTED;
            state_nxt  = S_DONE;
          end
        end
      end

      S_BASE: begin
        mac_en          = 1'b1;
        mac_a           = A_W'(chunk_r);
        mac_b           = cfg.units;
        ram_we          = 1'b1;
        valid_nxt[k_r]  = 1'b1;
        state_nxt       = S_OFF;
      end

      S_OFF: begin
        mac_en       = 1'b1;
        mac_a        = A_W'(used_r);
        mac_b        = grains_r;
        mac_c        = mac_p;
        use_addr_nxt = 1'b1;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = status_r;
          out_data_nxt.address = use_addr_r ? addr_wide[ADDR_W-1:0] : '0;
          state_nxt            = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  a_recyc_le_taken: assert property (@(posedge clk) disable iff (!rst_n)
    recyc_r <= taken_r)
    else $error("recycled count exceeds chunks taken");

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= CNT_W'(MAX_CHUNKS))
    else $error("chunks taken beyond pool size");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(k_r)])
    else $error("slot table write did not mark class valid");

  a_write_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(chunk_r) < CNT_W'(MAX_CHUNKS)))
    else $error("chunk index outside pool");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.address == '0))
    else $error("failed allocation carries an address");

endmodule

@@ rtl/size_class_slab_allocator.sv @@
// Top level of the size-class slab allocator: configuration registers and sequencer.
// Depends on scsa_pkg and scsa_seq.
`timescale 1ns / 1ps

// Each transaction on the input channel is one command and yields exactly one result.
// An allocate steps through the size, look, pick, base and offset states before its result
// reaches the output register, and no new command is accepted until that result is there.
// Reset, clear and the unused command code go straight to the done state; a failed size
// check leaves after the size state and an exhausted pool after the pick state. The allocate
// path is one registered read of the per-class slot table followed by three passes
// through a single shared multiply-accumulate unit (capacity check, chunk base, slot
// offset). The input side stalls while a command is in flight or its result cannot
// yet be placed in the output register. No clearing pass runs after reset: per-class
// valid bits are flip-flops cleared at once, and slot table contents are only used for
// classes marked valid. Configuration is taken at any time on the cfg_ port but
// should only be written while the block is idle.
module size_class_slab_allocator #(
  parameter int MAX_CLASSES = scsa_pkg::DEF_MAX_CLASSES,
  parameter int MAX_CHUNKS  = scsa_pkg::DEF_MAX_CHUNKS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  scsa_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output scsa_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import scsa_pkg::*;

  logic [GS_W-1:0]    grain_shift_r, grain_shift_nxt;
  logic [UNITS_W-1:0] chunk_units_r, chunk_units_nxt;
  cfg_t               cfg_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grain_shift_r <= RST_GRAIN_SHIFT;
      chunk_units_r <= RST_CHUNK_UNITS;
    end else begin
      grain_shift_r <= grain_shift_nxt;
      chunk_units_r <= chunk_units_nxt;
    end
  end

  always_comb begin
    grain_shift_nxt = grain_shift_r;
    chunk_units_nxt = chunk_units_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRAIN_SHIFT: grain_shift_nxt = cfg_data[GS_W-1:0];
        REG_CHUNK_UNITS: chunk_units_nxt = cfg_data[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp granule and class count to the supported range
  always_comb begin
    if (grain_shift_r < MIN_GRAIN_SHIFT) begin
      cfg_eff.grain_shift = MIN_GRAIN_SHIFT;
    end else if (grain_shift_r > MAX_GRAIN_SHIFT) begin
      cfg_eff.grain_shift = MAX_GRAIN_SHIFT;
    end else begin
      cfg_eff.grain_shift = grain_shift_r;
    end
    if (int'(chunk_units_r) > MAX_CLASSES) begin
      cfg_eff.units = UNITS_W'(MAX_CLASSES);
    end else begin
      cfg_eff.units = chunk_units_r;
    end
  end

  scsa_seq #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_eff),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
